@@ rtl/lnc_pkg.sv @@
// Package for the LRU name cache: word types, request codes and cell commands.
// Used by lnc_cell and lru_name_cache; depends on nothing else.
package lnc_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W       = $clog2(MAX_ENTRIES);
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

   localparam logic [1:0] FUNC_LOOKUP     = 2'd0;
   localparam logic [1:0] FUNC_INSERT     = 2'd1;
   localparam logic [1:0] FUNC_INVALIDATE = 2'd2;
   localparam logic [1:0] FUNC_FLUSH      = 2'd3;

   localparam logic [2:0] OP_NONE   = 3'd0;
   localparam logic [2:0] OP_CMP    = 3'd1;
   localparam logic [2:0] OP_HIT    = 3'd2;
   localparam logic [2:0] OP_UPDATE = 3'd3;
   localparam logic [2:0] OP_REMOVE = 3'd4;
   localparam logic [2:0] OP_EVICT  = 3'd5;
   localparam logic [2:0] OP_INSERT = 3'd6;
   localparam logic [2:0] OP_FLUSH  = 3'd7;

   typedef struct packed {
      logic [1:0]  func;
      logic [63:0] key;
      logic [31:0] value;
      logic        negative_in;
   } req_type;

   typedef struct packed {
      logic             hit;
      logic             negative_out;
      logic [31:0]      value_out;
      logic [31:0]      entry_hits;
      logic             evicted;
      logic [CNT_W-1:0] entry_count;
      logic [31:0]      lookup_total;
      logic [31:0]      hit_total;
      logic [31:0]      miss_total;
      logic [31:0]      insert_total;
      logic [31:0]      eviction_total;
   } rsp_type;

   // Command broadcast to every cell.
   typedef struct packed {
      logic [2:0]       op;
      logic [63:0]      key;
      logic [31:0]      value;
      logic             negative;
      logic [IDX_W-1:0] rank;
   } cmd_type;

   // Contents of the selected cell, zero from every other cell.
   typedef struct packed {
      logic [IDX_W-1:0] rank;
      logic [31:0]      value;
      logic             negative;
      logic [31:0]      hits;
   } cell_rd_type;

endpackage

@@ rtl/lru_name_cache.sv @@
// Top level of the LRU name cache: request sequencer, counters and result register.
// Depends on lnc_pkg and lnc_cell.
//
// Usage: a request word (func, key, value, negative_in) is taken on req_valid with
// req_stall low. Lookup, insert, invalidate and flush each give exactly one result
// word on rsp_valid, taken when rsp_stall is low. The user must write the capacity
// register through csr_wr_en and csr_wr_data only while the block is idle; the block
// does not enforce this. Zero or a value above the entry count means all entries.
// Steps: a request goes through the key compare in all cells (ST_CMP), the action
// (ST_ACT) and the hand-off to the result register (ST_DONE). An insert of a new key
// adds ST_INSERT for the new entry, preceded by ST_EVICT, which evicts one entry a
// cycle until the entry count is below the capacity.
// The block works on one request at a time and takes no new one until the last has
// left ST_DONE, since all cells share one compare and update.
// A finished result waits in the output register while the next request is accepted
// and worked on; only the final hand-off to the register waits on a stalled receiver.
// Reset clears all valid bits, the entry count, the statistics and sets the capacity
// to the full entry count; no clearing pass is needed.
module lru_name_cache (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lnc_pkg::req_type    req_word,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lnc_pkg::rsp_type    rsp_word,
   input  logic                csr_wr_en,
   input  logic [6:0]          csr_wr_data
);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_CMP    = 3'd1;
   localparam logic [2:0] ST_ACT    = 3'd2;
   localparam logic [2:0] ST_EVICT  = 3'd3;
   localparam logic [2:0] ST_INSERT = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   localparam int N = lnc_pkg::MAX_ENTRIES;
   localparam logic [lnc_pkg::CNT_W-1:0] FULL = lnc_pkg::CNT_W'(N);

   logic [2:0]                state_ff, state_in;
   lnc_pkg::req_type          req_ff, req_in;
   logic [6:0]                cap_ff, cap_in;
   logic [lnc_pkg::CNT_W-1:0] count_ff, count_in, eff_cap;
   logic [31:0]               lookups_ff, lookups_in, hitst_ff, hitst_in;
   logic [31:0]               misses_ff, misses_in, inserts_ff, inserts_in;
   logic [31:0]               evicts_ff, evicts_in;
   logic                      p_hit_ff, p_hit_in, p_neg_ff, p_neg_in;
   logic [31:0]               p_val_ff, p_val_in, p_hits_ff, p_hits_in;
   logic                      p_ev_ff, p_ev_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   lnc_pkg::rsp_type          rsp_ff, rsp_in;
   lnc_pkg::cmd_type          cmd;
   logic [N:0]                mchain, fchain;
   lnc_pkg::cell_rd_type      rd [N];
   lnc_pkg::cell_rd_type      sel_rd;
   logic                      any_match, out_free;

   assign mchain[0] = 1'b0;
   assign fchain[0] = 1'b0;

   for (genvar g = 0; g < N; g++) begin : g_cell
      lnc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .mtaken_in  (mchain[g]),
         .mtaken_out (mchain[g+1]),
         .ftaken_in  (fchain[g]),
         .ftaken_out (fchain[g+1]),
         .rd         (rd[g])
      );
   end

   assign any_match = mchain[N];

   // Only the first matching cell drives nonzero data, so an OR gives its contents.
   always_comb begin
      sel_rd = '0;
      for (int i = 0; i < N; i++) begin
         sel_rd = sel_rd | rd[i];
      end
   end

   always_comb begin
      if (cap_ff == 7'd0 || {{(32-7){1'b0}}, cap_ff} > 32'(N)) begin
         eff_cap = FULL;
      end else begin
         eff_cap = lnc_pkg::CNT_W'(cap_ff);
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = ~rsp_valid_ff | ~rsp_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      cap_in       = csr_wr_en ? csr_wr_data : cap_ff;
      count_in     = count_ff;
      lookups_in   = lookups_ff;
      hitst_in     = hitst_ff;
      misses_in    = misses_ff;
      inserts_in   = inserts_ff;
      evicts_in    = evicts_ff;
      p_hit_in     = p_hit_ff;
      p_neg_in     = p_neg_ff;
      p_val_in     = p_val_ff;
      p_hits_in    = p_hits_ff;
      p_ev_in      = p_ev_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      cmd.op       = lnc_pkg::OP_NONE;
      cmd.key      = req_ff.key;
      cmd.value    = req_ff.negative_in ? 32'd0 : req_ff.value;
      cmd.negative = req_ff.negative_in;
      cmd.rank     = sel_rd.rank;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in   = req_word;
               state_in = ST_CMP;
            end
         end
         ST_CMP: begin
            cmd.op   = lnc_pkg::OP_CMP;
            state_in = ST_ACT;
         end
         ST_ACT: begin
            p_hit_in  = 1'b0;
            p_neg_in  = 1'b0;
            p_val_in  = '0;
            p_hits_in = '0;
            p_ev_in   = 1'b0;
            state_in  = ST_DONE;
            case (req_ff.func)
               lnc_pkg::FUNC_LOOKUP: begin
                  lookups_in = lookups_ff + 32'd1;
                  if (any_match) begin
                     cmd.op    = lnc_pkg::OP_HIT;
                     hitst_in  = hitst_ff + 32'd1;
                     p_hit_in  = 1'b1;
                     p_neg_in  = sel_rd.negative;
                     p_val_in  = sel_rd.value;
                     p_hits_in = sel_rd.hits + 32'd1;
                  end else begin
                     misses_in = misses_ff + 32'd1;
                  end
               end
               lnc_pkg::FUNC_INSERT: begin
                  if (any_match) begin
                     cmd.op = lnc_pkg::OP_UPDATE;
                  end else if (count_ff >= eff_cap) begin
                     state_in = ST_EVICT;
                  end else begin
                     state_in = ST_INSERT;
                  end
               end
               lnc_pkg::FUNC_INVALIDATE: begin
                  if (any_match) begin
                     cmd.op   = lnc_pkg::OP_REMOVE;
                     count_in = count_ff - 1'b1;
                  end
               end
               lnc_pkg::FUNC_FLUSH: begin
                  cmd.op   = lnc_pkg::OP_FLUSH;
                  count_in = '0;
               end
               default: begin
               end
            endcase
         end
         ST_EVICT: begin
            // The least recent entry holds rank count-1; the count is at least one here.
            cmd.op    = lnc_pkg::OP_EVICT;
            cmd.rank  = lnc_pkg::IDX_W'(count_ff - 1'b1);
            count_in  = count_ff - 1'b1;
            evicts_in = evicts_ff + 32'd1;
            p_ev_in   = 1'b1;
            if (count_ff - 1'b1 >= eff_cap) begin
               state_in = ST_EVICT;
            end else begin
               state_in = ST_INSERT;
            end
         end
         ST_INSERT: begin
            cmd.op     = lnc_pkg::OP_INSERT;
            count_in   = count_ff + 1'b1;
            inserts_in = inserts_ff + 32'd1;
            state_in   = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_in.hit            = p_hit_ff;
               rsp_in.negative_out   = p_neg_ff;
               rsp_in.value_out      = p_val_ff;
               rsp_in.entry_hits     = p_hits_ff;
               rsp_in.evicted        = p_ev_ff;
               rsp_in.entry_count    = count_ff;
               rsp_in.lookup_total   = lookups_ff;
               rsp_in.hit_total      = hitst_ff;
               rsp_in.miss_total     = misses_ff;
               rsp_in.insert_total   = inserts_ff;
               rsp_in.eviction_total = evicts_ff;
               rsp_valid_in          = 1'b1;
               state_in              = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= 7'd64;
         count_ff     <= '0;
         lookups_ff   <= '0;
         hitst_ff     <= '0;
         misses_ff    <= '0;
         inserts_ff   <= '0;
         evicts_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         lookups_ff   <= lookups_in;
         hitst_ff     <= hitst_in;
         misses_ff    <= misses_in;
         inserts_ff   <= inserts_in;
         evicts_ff    <= evicts_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_ff    <= req_in;
      p_hit_ff  <= p_hit_in;
      p_neg_ff  <= p_neg_in;
      p_val_ff  <= p_val_in;
      p_hits_ff <= p_hits_in;
      p_ev_ff   <= p_ev_in;
      rsp_ff    <= rsp_in;
   end

endmodule

@@ rtl/lnc_cell.sv @@
// One entry of the LRU name cache with its recency rank.
// Depends on lnc_pkg; chained to its neighbors through the select chains.
module lnc_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  lnc_pkg::cmd_type     cmd,
   input  logic                 mtaken_in,
   output logic                 mtaken_out,
   input  logic                 ftaken_in,
   output logic                 ftaken_out,
   output lnc_pkg::cell_rd_type rd
);

   logic                      valid_ff, valid_in;
   logic                      match_ff, match_in;
   logic [63:0]               key_ff, key_in;
   logic [31:0]               value_ff, value_in;
   logic                      neg_ff, neg_in;
   logic [31:0]               hits_ff, hits_in;
   logic [lnc_pkg::IDX_W-1:0] rank_ff, rank_in;
   logic                      msel, fsel, esel;

   // First match and first free slot are found along the chain, lowest index first.
   assign msel       = match_ff & ~mtaken_in;
   assign mtaken_out = mtaken_in | match_ff;
   assign fsel       = ~valid_ff & ~ftaken_in;
   assign ftaken_out = ftaken_in | ~valid_ff;
   assign esel       = valid_ff & (rank_ff == cmd.rank);

   assign rd.rank     = msel ? rank_ff : '0;
   assign rd.value    = msel ? value_ff : '0;
   assign rd.negative = msel & neg_ff;
   assign rd.hits     = msel ? hits_ff : '0;

   always_comb begin
      valid_in = valid_ff;
      match_in = match_ff;
      key_in   = key_ff;
      value_in = value_ff;
      neg_in   = neg_ff;
      hits_in  = hits_ff;
      rank_in  = rank_ff;
      case (cmd.op)
         lnc_pkg::OP_CMP: begin
            match_in = valid_ff & (key_ff == cmd.key);
         end
         lnc_pkg::OP_HIT: begin
            if (msel) begin
               hits_in = hits_ff + 32'd1;
               rank_in = '0;
            end else if (valid_ff && rank_ff < cmd.rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         lnc_pkg::OP_UPDATE: begin
            if (msel) begin
               value_in = cmd.value;
               neg_in   = cmd.negative;
               rank_in  = '0;
            end else if (valid_ff && rank_ff < cmd.rank) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         lnc_pkg::OP_REMOVE: begin
            if (msel) begin
               valid_in = 1'b0;
            end else if (valid_ff && rank_ff > cmd.rank) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         lnc_pkg::OP_EVICT: begin
            if (esel) begin
               valid_in = 1'b0;
            end else if (valid_ff && rank_ff > cmd.rank) begin
               rank_in = rank_ff - 1'b1;
            end
         end
         lnc_pkg::OP_INSERT: begin
            if (fsel) begin
               valid_in = 1'b1;
               key_in   = cmd.key;
               value_in = cmd.value;
               neg_in   = cmd.negative;
               hits_in  = '0;
               rank_in  = '0;
            end else if (valid_ff) begin
               rank_in = rank_ff + 1'b1;
            end
         end
         lnc_pkg::OP_FLUSH: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      match_ff <= match_in;
      key_ff   <= key_in;
      value_ff <= value_in;
      neg_ff   <= neg_in;
      hits_ff  <= hits_in;
      rank_ff  <= rank_in;
   end

endmodule
